/* rtl/gdo_pkg.sv */
// Shared types, constants, calendar helpers and the microcode store of the date offset core.
package gdo_pkg;

    localparam int MAX_OFFSET_BITS = 16;

    localparam int IN_W     = 40;
    localparam int OUT_W    = 24;
    localparam int DAY_W    = 18;   // signed running day, holds start day plus or minus offset
    localparam int YEAR_W   = 16;   // signed running year, covers the drift past both ends
    localparam int R400_W   = 14;   // year modulo 400; wide enough for the raw start year
    localparam int STEP_W   = 3;

    localparam logic [15:0] OFF_MASK = 16'((32'd1 << MAX_OFFSET_BITS) - 32'd1);

    localparam logic [R400_W-1:0] CYCLE_YEARS = R400_W'(400);
    localparam logic signed [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);
    localparam logic signed [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_MOD400,
        OP_MFIX,
        OP_NORM,
        OP_BORROW,
        OP_DONE
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_XFER,
        C_GE400,
        C_DAY_OVER,
        C_DAY_UNDER,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    localparam logic [STEP_W-1:0] S_IDLE   = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_MOD    = STEP_W'(1);
    localparam logic [STEP_W-1:0] S_MFIX   = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_NORM   = STEP_W'(3);
    localparam logic [STEP_W-1:0] S_BORROW = STEP_W'(4);
    localparam logic [STEP_W-1:0] S_DONE   = STEP_W'(5);

    // Jump to target when the condition holds, else fall through to the next step.
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            S_IDLE:   w = '{OP_LOAD,   C_NO_XFER,   S_IDLE};
            S_MOD:    w = '{OP_MOD400, C_GE400,     S_MOD};
            S_MFIX:   w = '{OP_MFIX,   C_NEVER,     S_IDLE};
            S_NORM:   w = '{OP_NORM,   C_DAY_OVER,  S_NORM};
            S_BORROW: w = '{OP_BORROW, C_DAY_UNDER, S_NORM};
            S_DONE:   w = '{OP_DONE,   C_OUT_FULL,  S_DONE};
            default:  w = '{OP_NOP,    C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

    // Leap test on the year taken modulo 400.
    function automatic logic is_leap(input logic [R400_W-1:0] r400);
        logic century;
        century = (r400 == R400_W'(100)) || (r400 == R400_W'(200)) ||
                  (r400 == R400_W'(300));
        return (r400[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* rtl/gregorian_date_offset_core.sv */
// Top level of the date offset core: microcoded sequencer and its month-step datapath.
//
//  channel  | direction | payload (low bit first)
//  ---------+-----------+------------------------------------------------------------------
//  s_axis   | in        | mode[0] start_day[5:1] start_month[9:6] start_year[23:10]
//           |           | offset_days[39:24]
//  m_axis   | out       | result_day[4:0] result_month[8:5] result_year[22:9] year_error[23]
//
// One item at a time. An item is loaded, its year is reduced modulo 400 and its month
// fixed; the day is then normalised a month at a time, by the NORM step for each month
// crossed forward and by the NORM and BORROW steps for each month stepped back, and the
// result is written out. The month-step loop of the sequencer dominates the time per item.
// rst_n clears the step counter and the output valid flag.
// A new item is taken while the previous result waits in the output register; the
// sequencer holds at its last step only if that register is still full.
module gregorian_date_offset_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // mode, start_day, start_month, start_year, offset_days
    input  logic [gdo_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // result_day, result_month, result_year, year_error
    output logic [gdo_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic [gdo_pkg::STEP_W-1:0]          step_reg, step_next;
    logic signed [gdo_pkg::DAY_W-1:0]    day_reg, day_next;
    logic [3:0]                          month_reg, month_next;
    logic signed [gdo_pkg::YEAR_W-1:0]   year_reg, year_next;
    logic [gdo_pkg::R400_W-1:0]          r400_reg, r400_next;
    logic                                out_valid_reg, out_valid_next;
    logic [gdo_pkg::OUT_W-1:0]           out_data_reg, out_data_next;

    gdo_pkg::uword_t                     uw;
    logic                                xfer_in;
    logic                                out_full;
    logic [4:0]                          len_cur;
    logic                                day_over;
    logic                                day_under;
    logic                                ge400;
    logic                                take;
    logic                                yr_inc;
    logic                                yr_dec;
    logic [15:0]                         off;
    logic signed [gdo_pkg::DAY_W-1:0]    off_ext;
    logic signed [gdo_pkg::DAY_W-1:0]    sday_ext;
    logic [13:0]                         ry;
    logic                                err;

    assign uw            = gdo_pkg::ucode(step_reg);
    assign s_axis_tready = (uw.op == gdo_pkg::OP_LOAD);
    assign xfer_in       = s_axis_tvalid && s_axis_tready;
    assign out_full      = out_valid_reg && !m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign len_cur   = gdo_pkg::month_len(month_reg, gdo_pkg::is_leap(r400_reg));
    assign day_over  = day_reg > $signed({{(gdo_pkg::DAY_W-5){1'b0}}, len_cur});
    assign day_under = day_reg < $signed(gdo_pkg::DAY_W'(1));
    assign ge400     = r400_reg >= gdo_pkg::CYCLE_YEARS;

    assign off      = s_axis_tdata[39:24] & gdo_pkg::OFF_MASK;
    assign off_ext  = $signed({{(gdo_pkg::DAY_W-16){1'b0}}, off});
    assign sday_ext = $signed({{(gdo_pkg::DAY_W-5){1'b0}}, s_axis_tdata[5:1]});

    // Clamp the year into the range 1 to 9999 and flag a year that falls outside it.
    always_comb
    begin
        if (year_reg < gdo_pkg::YEAR_MIN)
        begin
            ry  = 14'(gdo_pkg::YEAR_MIN);
            err = 1'b1;
        end
        else if (year_reg > gdo_pkg::YEAR_MAX)
        begin
            ry  = 14'(gdo_pkg::YEAR_MAX);
            err = 1'b1;
        end
        else
        begin
            ry  = year_reg[13:0];
            err = 1'b0;
        end
    end

    always_comb
    begin
        case (uw.cond)
            gdo_pkg::C_NEVER:     take = 1'b0;
            gdo_pkg::C_ALWAYS:    take = 1'b1;
            gdo_pkg::C_NO_XFER:   take = !xfer_in;
            gdo_pkg::C_GE400:     take = ge400;
            gdo_pkg::C_DAY_OVER:  take = day_over;
            gdo_pkg::C_DAY_UNDER: take = day_under;
            gdo_pkg::C_OUT_FULL:  take = out_full;
            default:              take = 1'b0;
        endcase
        step_next = take ? uw.target : step_reg + gdo_pkg::STEP_W'(1);
    end

    // Datapath driven by the current control word.
    always_comb
    begin
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        r400_next      = r400_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        yr_inc         = 1'b0;
        yr_dec         = 1'b0;

        case (uw.op)
            gdo_pkg::OP_LOAD:
            begin
                if (xfer_in)
                begin
                    day_next   = s_axis_tdata[0] ? sday_ext - off_ext : sday_ext + off_ext;
                    month_next = s_axis_tdata[9:6];
                    year_next  = $signed({{(gdo_pkg::YEAR_W-14){1'b0}}, s_axis_tdata[23:10]});
                    r400_next  = s_axis_tdata[23:10];
                end
            end
            gdo_pkg::OP_MOD400:
            begin
                if (ge400)
                begin
                    r400_next = r400_reg - gdo_pkg::CYCLE_YEARS;
                end
            end
            gdo_pkg::OP_MFIX:
            begin
                if (month_reg == 4'd0)
                begin
                    month_next = gdo_pkg::MONTH_DEC;
                    yr_dec     = 1'b1;
                end
                else if (month_reg > gdo_pkg::MONTH_DEC)
                begin
                    month_next = month_reg - gdo_pkg::MONTH_DEC;
                    yr_inc     = 1'b1;
                end
            end
            gdo_pkg::OP_NORM:
            begin
                if (day_over)
                begin
                    day_next = day_reg - $signed({{(gdo_pkg::DAY_W-5){1'b0}}, len_cur});
                    if (month_reg == gdo_pkg::MONTH_DEC)
                    begin
                        month_next = gdo_pkg::MONTH_JAN;
                        yr_inc     = 1'b1;
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else if (day_under)
                begin
                    // step the month back; the borrow step adds its length
                    if (month_reg == gdo_pkg::MONTH_JAN)
                    begin
                        month_next = gdo_pkg::MONTH_DEC;
                        yr_dec     = 1'b1;
                    end
                    else
                    begin
                        month_next = month_reg - 4'd1;
                    end
                end
            end
            gdo_pkg::OP_BORROW:
            begin
                if (day_under)
                begin
                    day_next = day_reg + $signed({{(gdo_pkg::DAY_W-5){1'b0}}, len_cur});
                end
            end
            gdo_pkg::OP_DONE:
            begin
                if (!out_full)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {err, ry, month_reg, day_reg[4:0]};
                end
            end
            default:
            begin
            end
        endcase

        // keep the year and its residue modulo 400 in step
        if (yr_inc)
        begin
            year_next = year_reg + gdo_pkg::YEAR_W'(1);
            r400_next = (r400_reg == gdo_pkg::CYCLE_YEARS - gdo_pkg::R400_W'(1)) ?
                        '0 : r400_reg + gdo_pkg::R400_W'(1);
        end
        else if (yr_dec)
        begin
            year_next = year_reg - gdo_pkg::YEAR_W'(1);
            r400_next = (r400_reg == '0) ?
                        gdo_pkg::CYCLE_YEARS - gdo_pkg::R400_W'(1) :
                        r400_reg - gdo_pkg::R400_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= gdo_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg      <= day_next;
        month_reg    <= month_next;
        year_reg     <= year_next;
        r400_reg     <= r400_next;
        out_data_reg <= out_data_next;
    end

endmodule
